// File: hw/rtl/gprmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPRMC time/date extractor package
// Character codes, field widths and the decoded time/date record.
// ----------------------------------------------------------------------------
package gprmc_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned FIELD_W = 8;
    localparam int unsigned OFF_W   = 4;
    localparam int unsigned NCHARS  = 6;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CH_A     = 8'd65;
    localparam logic [CHAR_W-1:0] CH_G     = 8'd71;
    localparam logic [CHAR_W-1:0] CH_M     = 8'd77;
    localparam logic [CHAR_W-1:0] CH_P     = 8'd80;
    localparam logic [CHAR_W-1:0] CH_R     = 8'd82;

    // Header match stages; STAGE_IN means inside a sentence
    localparam logic [2:0] STAGE_IDLE = 3'd0;
    localparam logic [2:0] STAGE_IN   = 3'd4;

    // Sentence positions and counters
    localparam int unsigned POS_TIME_FIRST = 6;
    localparam int unsigned POS_STATUS     = 16;
    localparam logic [3:0]  COMMA_DATE     = 4'd9;
    localparam logic [3:0]  COMMA_MAX      = 4'd15;
    localparam logic [2:0]  DATE_DIGITS    = 3'd6;

    // Decoded fields of one sentence
    typedef struct packed {
        logic [FIELD_W-1:0] year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] hour;
    } datetime_t;

    // Expected header character for a match stage below STAGE_IN
    function automatic logic [CHAR_W-1:0] header_char(input logic [2:0] stage);
        logic [CHAR_W-1:0] ch;
        unique case (stage[1:0])
            2'd0:    ch = CH_G;
            2'd1:    ch = CH_P;
            2'd2:    ch = CH_R;
            default: ch = CH_M;
        endcase
        return ch;
    endfunction

    // (lo - 48) + 10 * (hi - 48), modulo 256; 528 mod 256 is 16
    function automatic logic [FIELD_W-1:0] two_digits(input logic [CHAR_W-1:0] hi,
                                                      input logic [CHAR_W-1:0] lo);
        return lo + {hi[4:0], 3'b000} + {hi[6:0], 1'b0} - 8'd16;
    endfunction

endpackage

// File: hw/rtl/gprmc_time_date_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPRMC time/date extractor core
// Parses a received character stream, decodes hhmmss and ddmmyy of a GPRMC
// sentence and converts UTC to local time with a day/month/year rollback.
// ----------------------------------------------------------------------------
// Usage:
//   s_*   : one received ASCII character per transfer on s_tdata.
//   m_*   : one time/date record per valid sentence (status 'A'), given once
//           per line, when the sixth date character is taken. m_tuser holds
//           the time and date validity flags.
//   cfg_* : writes hours_behind_utc (low 4 bits); cfg_ready is always high.
// Throughput: one character per cycle while s_tready is high. Each character
//   updates the parse state in the cycle it is taken; a record then goes
//   through a decode register and the rollback logic into the output
//   register, which drives m_tvalid.
// Reset: the parse state clears, hours_behind_utc returns to 5, no record is
//   pending. A CR LF pair clears the parse state as well.
// Stall: while m_tready is low the output register holds its record; the
//   decode register still takes one more record, and s_tready drops only
//   when both hold a record.
// ----------------------------------------------------------------------------
module gprmc_time_date_extractor_core #(
    parameter int unsigned LINE_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // received characters: [7:0] rx_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // records: [7:0] hour, [15:8] minute, [23:16] second, [31:24] day,
    //          [39:32] month, [47:40] year
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // flags: [0] time_ok, [1] date_ok
    output logic [1:0]  m_tuser,
    // configuration: [3:0] hours_behind_utc
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int unsigned POS_W = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    localparam int unsigned CW = gprmc_pkg::CHAR_W;
    localparam int unsigned FW = gprmc_pkg::FIELD_W;

    // Parse state
    logic [2:0]       stage_reg, stage_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       comma_reg, comma_next;
    logic [2:0]       ddc_reg, ddc_next;
    logic [CW-1:0]    time_reg [gprmc_pkg::NCHARS];
    logic [CW-1:0]    time_next [gprmc_pkg::NCHARS];
    logic [CW-1:0]    date_reg [gprmc_pkg::NCHARS];
    logic [CW-1:0]    date_next [gprmc_pkg::NCHARS];
    logic             status_reg, status_next;
    logic             taken_reg, taken_next;
    logic             cr_reg, cr_next;
    logic             emit;

    // Configuration
    logic [gprmc_pkg::OFF_W-1:0] offset_reg;

    // Decode stage and output register
    logic                  mid_valid_reg;
    gprmc_pkg::datetime_t  mid_reg;
    logic                  out_valid_reg;
    gprmc_pkg::datetime_t  out_reg;
    logic [1:0]            flags_reg;

    logic in_xfer, out_load, mid_load;
    gprmc_pkg::datetime_t dec, local_dt;
    logic [1:0] local_flags;

    // Handshakes
    assign out_load  = !out_valid_reg || m_tready;
    assign s_tready  = !mid_valid_reg || out_load;
    assign in_xfer   = s_tvalid && s_tready;
    assign mid_load  = in_xfer && emit;
    assign cfg_ready = 1'b1;

    // Parse one character
    always_comb
    begin
        stage_next  = stage_reg;
        pos_next    = pos_reg;
        comma_next  = comma_reg;
        ddc_next    = ddc_reg;
        time_next   = time_reg;
        date_next   = date_reg;
        status_next = status_reg;
        taken_next  = taken_reg;
        cr_next     = cr_reg;
        emit        = 1'b0;

        if (cr_reg && s_tdata == gprmc_pkg::CH_LF)
        begin
            // line end: clear everything
            stage_next  = gprmc_pkg::STAGE_IDLE;
            pos_next    = '0;
            comma_next  = '0;
            ddc_next    = '0;
            for (int i = 0; i < gprmc_pkg::NCHARS; i++)
            begin
                time_next[i] = '0;
                date_next[i] = '0;
            end
            status_next = 1'b0;
            taken_next  = 1'b0;
            cr_next     = 1'b0;
        end
        else
        begin
            cr_next = (s_tdata == gprmc_pkg::CH_CR);
            if (stage_reg != gprmc_pkg::STAGE_IN)
            begin
                // header search
                if (s_tdata == gprmc_pkg::header_char(stage_reg))
                begin
                    stage_next = stage_reg + 3'd1;
                    pos_next   = POS_W'(stage_reg);
                end
                else
                begin
                    stage_next = (s_tdata == gprmc_pkg::CH_G) ? 3'd1 : gprmc_pkg::STAGE_IDLE;
                    pos_next   = '0;
                end
            end
            else if (pos_reg < POS_LAST)
            begin
                pos_next = pos_reg + POS_W'(1);
                // capture time characters
                for (int i = 0; i < gprmc_pkg::NCHARS; i++)
                begin
                    if (pos_next == POS_W'(gprmc_pkg::POS_TIME_FIRST + i))
                        time_next[i] = s_tdata;
                end
                if (pos_next == POS_W'(gprmc_pkg::POS_STATUS))
                    status_next = (s_tdata == gprmc_pkg::CH_A);
                // capture date characters after the ninth comma
                if (comma_reg >= gprmc_pkg::COMMA_DATE && ddc_reg < gprmc_pkg::DATE_DIGITS)
                begin
                    for (int i = 0; i < gprmc_pkg::NCHARS; i++)
                    begin
                        if (ddc_reg == 3'(i))
                            date_next[i] = s_tdata;
                    end
                    ddc_next = ddc_reg + 3'd1;
                    if (ddc_next == gprmc_pkg::DATE_DIGITS && status_next && !taken_reg)
                    begin
                        taken_next = 1'b1;
                        emit       = 1'b1;
                    end
                end
                if (s_tdata == gprmc_pkg::CH_COMMA && comma_reg < gprmc_pkg::COMMA_MAX)
                    comma_next = comma_reg + 4'd1;
            end
        end
    end

    // Decode the six two-digit fields from the updated characters
    always_comb
    begin
        dec.hour   = gprmc_pkg::two_digits(time_next[0], time_next[1]);
        dec.minute = gprmc_pkg::two_digits(time_next[2], time_next[3]);
        dec.second = gprmc_pkg::two_digits(time_next[4], time_next[5]);
        dec.day    = gprmc_pkg::two_digits(date_next[0], date_next[1]);
        dec.month  = gprmc_pkg::two_digits(date_next[2], date_next[3]);
        dec.year   = gprmc_pkg::two_digits(date_next[4], date_next[5]);
    end

    // Local time and date rollback
    always_comb
    begin
        logic [FW-1:0] off8;
        logic [8:0]    y99;
        logic [FW-1:0] prev_month;

        off8       = FW'(offset_reg);
        local_dt   = mid_reg;
        y99        = {1'b0, mid_reg.year} + 9'd99;
        prev_month = mid_reg.month - 8'd1;

        if (mid_reg.hour < off8)
        begin
            local_dt.hour = mid_reg.hour + 8'd24 - off8;
            if (mid_reg.day == 8'd1)
            begin
                priority if (mid_reg.month == 8'd1)
                begin
                    // year + 99 is below 400: subtract 100 up to three times
                    if (y99 >= 9'd300)
                        local_dt.year = FW'(y99 - 9'd300);
                    else if (y99 >= 9'd200)
                        local_dt.year = FW'(y99 - 9'd200);
                    else if (y99 >= 9'd100)
                        local_dt.year = FW'(y99 - 9'd100);
                    else
                        local_dt.year = FW'(y99);
                    local_dt.month = 8'd12;
                    local_dt.day   = 8'd31;
                end
                else if (mid_reg.month == 8'd3)
                begin
                    local_dt.month = 8'd2;
                    local_dt.day   = 8'd28;
                end
                else
                begin
                    local_dt.month = prev_month;
                    local_dt.day   = (prev_month == 8'd4 || prev_month == 8'd6 ||
                                      prev_month == 8'd9 || prev_month == 8'd11)
                                     ? 8'd30 : 8'd31;
                end
            end
            else
            begin
                local_dt.day = mid_reg.day - 8'd1;
            end
        end
        else
        begin
            local_dt.hour = mid_reg.hour - off8;
        end

        local_flags[0] = (local_dt.hour < 8'd24) && (local_dt.minute < 8'd60)
                         && (local_dt.second < 8'd60);
        local_flags[1] = (local_dt.day < 8'd32) && (local_dt.month < 8'd13);
    end

    // Parse state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= gprmc_pkg::STAGE_IDLE;
            pos_reg    <= '0;
            comma_reg  <= '0;
            ddc_reg    <= '0;
            for (int i = 0; i < gprmc_pkg::NCHARS; i++)
            begin
                time_reg[i] <= '0;
                date_reg[i] <= '0;
            end
            status_reg <= 1'b0;
            taken_reg  <= 1'b0;
            cr_reg     <= 1'b0;
            offset_reg <= 4'd5;
        end
        else
        begin
            if (in_xfer)
            begin
                stage_reg  <= stage_next;
                pos_reg    <= pos_next;
                comma_reg  <= comma_next;
                ddc_reg    <= ddc_next;
                time_reg   <= time_next;
                date_reg   <= date_next;
                status_reg <= status_next;
                taken_reg  <= taken_next;
                cr_reg     <= cr_next;
            end
            if (cfg_valid && cfg_ready)
                offset_reg <= cfg_data;
        end
    end

    // Decode register and output register valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= mid_valid_reg;
            if (mid_load)
                mid_valid_reg <= 1'b1;
            else if (out_load)
                mid_valid_reg <= 1'b0;
        end
    end

    // Record payloads
    always_ff @(posedge clk)
    begin
        if (mid_load)
            mid_reg <= dec;
        if (out_load && mid_valid_reg)
        begin
            out_reg   <= local_dt;
            flags_reg <= local_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = flags_reg;

endmodule
